// ===== rtl/bcqh_pkg.sv =====
// Shared types and constants for the bit crusher with sample and hold.
// Used by bcqh_crush and bitcrusher_quantize_hold_top; depends on nothing.
package bcqh_pkg;

	localparam int DEF_MAX_CHANNELS = 8;
	localparam int DEF_SAMPLE_BITS  = 24;

	localparam int DEPTH_W    = 6;
	localparam int STEP_W     = 17;
	localparam int COUNT_W    = 4;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CMP_W      = 6;
	localparam int P_W        = 32;

	localparam int DEPTH_MIN = 1;
	localparam int DEPTH_MAX = 32;

	localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(32);
	localparam logic [STEP_W-1:0]  STEP_ONE    = STEP_W'(65536);
	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

	localparam logic [CFG_IDX_W-1:0] CFG_BIT_DEPTH       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWNSAMPLE_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 2'd2;

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_CRUSH,
		TS_OUT
	} top_state_t;

	typedef enum logic [2:0] {
		CR_IDLE,
		CR_MUL,
		CR_QUANT,
		CR_NUM,
		CR_MAG,
		CR_DIV,
		CR_SAT
	} crush_state_t;

endpackage

// ===== rtl/bcqh_crush.sv =====
// Quantizer: multiply onto the depth grid, round, then a serial restoring
// divide back to sample scale and saturate. Depends on bcqh_pkg.
module bcqh_crush import bcqh_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [DEPTH_W-1:0]            depth,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] result
);

	localparam int PROD_W  = SAMPLE_BITS + P_W + 1;
	localparam int GRID_SH = SAMPLE_BITS + 2;
	localparam int Q_W     = PROD_W + 1 - GRID_SH;
	localparam int NUM_W   = Q_W + GRID_SH + 1;
	localparam int QUO_W   = SAMPLE_BITS + 1;
	localparam int CNT_W   = $clog2(QUO_W);

	localparam logic signed [PROD_W:0] ROUND = (PROD_W + 1)'(1) << (GRID_SH - 1);
	localparam logic signed [QUO_W:0]  SAT_HI =
		(QUO_W + 1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [QUO_W:0]  SAT_LO = -SAT_HI - (QUO_W + 1)'(1);

	crush_state_t state_q, state_d;

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [P_W-1:0]                p_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [Q_W-1:0]         q_q;
	logic signed [NUM_W-1:0]       n_q;
	logic                          neg_q;
	logic [P_W-1:0]                rem_q;
	logic [QUO_W-1:0]              dq_q;
	logic [CNT_W-1:0]              cnt_q;

	logic [P_W-1:0]           p_base;
	logic [P_W-1:0]           p_next;
	logic signed [PROD_W:0]   q_sum;
	logic [NUM_W-1:0]         mag;
	logic [P_W:0]             trial;
	logic [P_W:0]             diff;
	logic                     ge;
	logic signed [QUO_W:0]    value;

	always_comb begin
		p_base = P_W'(DEPTH_W'(DEPTH_MAX + 1) - depth);
		p_next = p_base << (depth - DEPTH_W'(1));
		q_sum  = {prod_q[PROD_W-1], prod_q} + ROUND;
		mag    = n_q[NUM_W-1] ? (~n_q + NUM_W'(p_q)) : n_q;
		trial  = {rem_q, dq_q[QUO_W-1]};
		diff   = trial - {1'b0, p_q};
		ge     = trial >= {1'b0, p_q};
		value  = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
		if (value > SAT_HI) begin
			result = SAT_HI[SAMPLE_BITS-1:0];
		end else if (value < SAT_LO) begin
			result = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			result = value[SAMPLE_BITS-1:0];
		end
	end

	assign done = (state_q == CR_SAT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CR_IDLE:  if (start) state_d = CR_MUL;
			CR_MUL:   state_d = CR_QUANT;
			CR_QUANT: state_d = CR_NUM;
			CR_NUM:   state_d = CR_MAG;
			CR_MAG:   state_d = CR_DIV;
			CR_DIV:   if (cnt_q == '0) state_d = CR_SAT;
			CR_SAT:   state_d = CR_IDLE;
			default:  state_d = CR_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			CR_IDLE: begin
				if (start) begin
					sample_q <= sample;
					p_q      <= p_next;
				end
			end
			CR_MUL: begin
				prod_q <= PROD_W'(sample_q * $signed({1'b0, p_q}));
			end
			CR_QUANT: begin
				q_q <= q_sum[PROD_W:GRID_SH];
			end
			CR_NUM: begin
				n_q <= $signed({q_q[Q_W-1], q_q, GRID_SH'(0)}) + $signed(NUM_W'(p_q[P_W-1:1]));
			end
			CR_MAG: begin
				neg_q <= n_q[NUM_W-1];
				rem_q <= mag[QUO_W+P_W-1:QUO_W];
				dq_q  <= mag[QUO_W-1:0];
				cnt_q <= CNT_W'(QUO_W - 1);
			end
			CR_DIV: begin
				rem_q <= ge ? diff[P_W-1:0] : trial[P_W-1:0];
				dq_q  <= {dq_q[QUO_W-2:0], ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/bitcrusher_quantize_hold_top.sv =====
// Bit crusher with sample and hold over interleaved channels.
// Updating frames pass through the quantizer, whose serial divider takes SAMPLE_BITS+1 steps;
// held frames skip it. A new word is accepted only once the previous one is loaded into the output register.
// Reset clears hold registers, phase, channel position and output valid; loads register defaults.
// Depends on bcqh_pkg and bcqh_crush.
module bitcrusher_quantize_hold_top import bcqh_pkg::*; #(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);

	localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	top_state_t state_q, state_d;

	logic [DEPTH_W-1:0] depth_q;
	logic [STEP_W-1:0]  step_q;
	logic [COUNT_W-1:0] count_q;

	logic [STEP_W-1:0]             phase_q;
	logic [POS_W-1:0]              pos_q;
	logic [POS_W-1:0]              ch_q;
	logic                          upd_q;
	logic signed [SAMPLE_BITS-1:0] held_q [MAX_CHANNELS];
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;

	logic                          accept;
	logic                          out_load;
	logic [DEPTH_W-1:0]            depth_eff;
	logic [STEP_W-1:0]             step_eff;
	logic [CMP_W-1:0]              count_eff;
	logic [POS_W-1:0]              pos_eff;
	logic [CMP_W-1:0]              pos_inc;
	logic [STEP_W:0]               phase_sum;
	logic                          first_ch;
	logic                          upd_d;
	logic [STEP_W-1:0]             phase_d;
	logic                          crush_done;
	logic signed [SAMPLE_BITS-1:0] crush_result;

	assign in_stall   = (state_q != TS_IDLE);
	assign accept     = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign sample_out = out_data_q;
	assign out_load   = (state_q == TS_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		if (depth_q < DEPTH_W'(DEPTH_MIN)) begin
			depth_eff = DEPTH_W'(DEPTH_MIN);
		end else if (depth_q > DEPTH_W'(DEPTH_MAX)) begin
			depth_eff = DEPTH_W'(DEPTH_MAX);
		end else begin
			depth_eff = depth_q;
		end
		step_eff = (step_q > STEP_ONE) ? STEP_ONE : step_q;
		if (count_q == '0) begin
			count_eff = CMP_W'(1);
		end else if (CMP_W'(count_q) > CMP_W'(MAX_CHANNELS)) begin
			count_eff = CMP_W'(MAX_CHANNELS);
		end else begin
			count_eff = CMP_W'(count_q);
		end
		pos_eff   = (CMP_W'(pos_q) >= count_eff) ? '0 : pos_q;
		pos_inc   = CMP_W'(pos_eff) + CMP_W'(1);
		first_ch  = (pos_eff == '0);
		phase_sum = {1'b0, phase_q} + {1'b0, step_eff};
		if (!first_ch) begin
			upd_d   = upd_q;
			phase_d = phase_q;
		end else if (phase_sum >= {1'b0, STEP_ONE}) begin
			upd_d   = 1'b1;
			phase_d = STEP_W'(phase_sum - {1'b0, STEP_ONE});
		end else begin
			upd_d   = 1'b0;
			phase_d = phase_sum[STEP_W-1:0];
		end
	end

	bcqh_crush #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_crush (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && upd_d),
		.sample (sample_in),
		.depth  (depth_eff),
		.done   (crush_done),
		.result (crush_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RESET;
			step_q  <= STEP_ONE;
			count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BIT_DEPTH:       depth_q <= cfg_data[DEPTH_W-1:0];
				CFG_DOWNSAMPLE_STEP: step_q  <= cfg_data[STEP_W-1:0];
				CFG_CHANNEL_COUNT:   count_q <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			TS_IDLE:  if (accept) state_d = upd_d ? TS_CRUSH : TS_OUT;
			TS_CRUSH: if (crush_done) state_d = TS_OUT;
			TS_OUT:   if (out_load) state_d = TS_IDLE;
			default:  state_d = TS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			pos_q   <= '0;
			ch_q    <= '0;
			upd_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			upd_q   <= upd_d;
			ch_q    <= pos_eff;
			pos_q   <= (pos_inc >= count_eff) ? '0 : pos_inc[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				held_q[i] <= '0;
			end
		end else if ((state_q == TS_CRUSH) && crush_done) begin
			held_q[ch_q] <= crush_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= held_q[ch_q];
		end
	end

endmodule
